[hw/rtl/bc_pkg.sv]
// ----------------------------------------------------------------------------
// bc_pkg
// Shared types and constants for the betweenness centrality engine.
// ----------------------------------------------------------------------------
package bc_pkg;

  // item function codes
  localparam logic [1:0] FUNC_OFFSET = 2'd0;
  localparam logic [1:0] FUNC_COLUMN = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // configuration register indexes
  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_EDGE_COUNT   = 1'b1;

  localparam int PC_W    = 32;
  localparam int SCORE_W = 48;
  localparam int Q_FRAC  = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] index;
    logic [12:0] value;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [9:0]         vertex;
    logic               status;
  } out_item_t;

  // operands for one dependency term
  typedef struct packed {
    logic [PC_W-1:0]    pcv;
    logic [PC_W-1:0]    pcw;
    logic [SCORE_W-1:0] dep;
  } ratio_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DRAIN, ST_CLR_CENT, ST_SRC, ST_CLR, ST_INIT,
    ST_F_POP, ST_F_V, ST_F_OFF0, ST_F_OFF1, ST_F_EDGE, ST_F_COL, ST_F_W,
    ST_B_POP, ST_B_V, ST_B_OFF0, ST_B_OFF1, ST_B_EDGE, ST_B_COL, ST_B_W,
    ST_B_WAIT, ST_B_STORE, ST_B_CENT, ST_DONE, ST_RST_CLR
  } bc_state_t;

  typedef enum logic [2:0] {
    RT_IDLE, RT_DIV, RT_MUL_HI, RT_MUL_LO, RT_SUM
  } ratio_state_t;

endpackage

[hw/rtl/betweenness_centrality.sv]
// Table writes and score reads: one item per cycle while the output side keeps
// up; each result passes the result stage, then the output register.
// Run: a clear of all MAX_VERTICES scores, then per source a clear of the live
// distance, path count and dependency entries, a forward search and a backward
// sweep; each dependency term waits on the shared ratio unit.
// Reset (synchronous) clears control state and both configuration registers,
// then clears all MAX_VERTICES scores while in_ready stays low.
// ----------------------------------------------------------------------------
// betweenness_centrality
// Brandes betweenness centrality engine over a CSR graph in on-chip tables.
// ----------------------------------------------------------------------------
module betweenness_centrality #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  bc_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bc_pkg::out_item_t out_data
);
  import bc_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DW  = VW + 1;
  localparam int OAW = $clog2(MAX_VERTICES + 1);
  localparam int OW  = $clog2(MAX_EDGES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam logic [DW-1:0] DIST_NONE = {DW{1'b1}};

  // configuration
  logic [10:0] vertex_count;
  logic [12:0] edge_count;
  logic [31:0] n32, m32, idx32, val32;
  logic [DW-1:0] live_n;
  logic [OW-1:0] live_m;

  // engine registers
  bc_state_t state, state_next;
  logic [DW-1:0] src, src_next, cnt, cnt_next, head, head_next, tail, tail_next;
  logic [DW-1:0] dv, dv_next;
  logic [VW-1:0] v, v_next, w, w_next;
  logic [OW-1:0] j, j_next, jend, jend_next;
  logic [PC_W-1:0] pcv, pcv_next;
  logic [SCORE_W-1:0] acc, acc_next;

  // result stage and output register
  logic      s1_valid, s1_use_ram, s1_move, s1_load, s1_load_use;
  out_item_t s1_data, s1_load_data;

  // memory ports
  logic off_we, col_we, dist_we, pc_we, dep_we, cent_we, vo_we, cent_re;
  logic [OAW-1:0] off_waddr, off_raddr;
  logic [OW-1:0]  off_wdata, off_rdata;
  logic [EW-1:0]  col_waddr, col_raddr;
  logic [VW-1:0]  col_wdata, col_rdata;
  logic [VW-1:0]  dist_waddr, dist_raddr, pc_waddr, pc_raddr, dep_waddr, dep_raddr;
  logic [VW-1:0]  cent_waddr, cent_raddr, vo_waddr, vo_raddr, vo_wdata, vo_rdata;
  logic [DW-1:0]  dist_wdata, dist_rdata;
  logic [PC_W-1:0] pc_wdata, pc_rdata;
  logic [SCORE_W-1:0] dep_wdata, dep_rdata, cent_wdata, cent_rdata;

  // ratio unit
  logic ratio_start, ratio_done;
  ratio_req_t ratio_req;
  logic [SCORE_W-1:0] ratio_term;

  // arithmetic helpers
  logic [DW-1:0] dv_inc, dist_eff;
  logic [PC_W:0] pc_sum;
  logic [SCORE_W:0] acc_sum, cent_sum;
  logic err;

  // live sizes, clamped to the table sizes
  always_comb begin
    n32 = (32'(vertex_count) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                  : 32'(vertex_count);
    m32 = (32'(edge_count) > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : 32'(edge_count);
    live_n = n32[DW-1:0];
    live_m = m32[OW-1:0];
    idx32 = 32'(in_data.index);
    val32 = 32'(in_data.value);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      edge_count   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[10:0];
        CFG_EDGE_COUNT:   edge_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) && (!s1_valid || s1_move);

  // sequencer: next state, table accesses and result loads
  always_comb begin
    state_next = state;
    src_next = src;  cnt_next = cnt;  head_next = head;  tail_next = tail;
    dv_next = dv;    v_next = v;      w_next = w;
    j_next = j;      jend_next = jend; pcv_next = pcv;   acc_next = acc;
    off_we = 1'b0;  off_waddr = '0; off_wdata = '0; off_raddr = '0;
    col_we = 1'b0;  col_waddr = '0; col_wdata = '0; col_raddr = '0;
    dist_we = 1'b0; dist_waddr = '0; dist_wdata = '0; dist_raddr = '0;
    pc_we = 1'b0;   pc_waddr = '0;  pc_wdata = '0;  pc_raddr = '0;
    dep_we = 1'b0;  dep_waddr = '0; dep_wdata = '0; dep_raddr = '0;
    cent_we = 1'b0; cent_waddr = '0; cent_wdata = '0; cent_raddr = '0;
    cent_re = 1'b0;
    vo_we = 1'b0;   vo_waddr = '0;  vo_wdata = '0;  vo_raddr = '0;
    ratio_start = 1'b0;
    ratio_req = '{pcv: pcv, pcw: pc_rdata, dep: dep_rdata};
    s1_load = 1'b0; s1_load_use = 1'b0; s1_load_data = '0;
    err = 1'b0;
    dv_inc = dv + DW'(1);
    dist_eff = (dist_rdata == DIST_NONE) ? dv_inc : dist_rdata;
    pc_sum = {1'b0, pc_rdata} + {1'b0, pcv};
    acc_sum = {1'b0, acc} + {1'b0, ratio_term};
    cent_sum = {1'b0, cent_rdata} + {1'b0, acc};

    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.func)
            FUNC_OFFSET: begin
              err = (idx32 > 32'(MAX_VERTICES)) || (val32 > 32'(MAX_EDGES));
              off_we = !err;
              off_waddr = idx32[OAW-1:0];
              off_wdata = val32[OW-1:0];
              s1_load = 1'b1;
              s1_load_data.status = err;
            end
            FUNC_COLUMN: begin
              err = (idx32 >= 32'(live_m)) || (val32 >= 32'(MAX_VERTICES));
              col_we = !err;
              col_waddr = idx32[EW-1:0];
              col_wdata = val32[VW-1:0];
              s1_load = 1'b1;
              s1_load_data.status = err;
            end
            FUNC_READ: begin
              err = idx32 >= 32'(live_n);
              cent_re = 1'b1;
              cent_raddr = idx32[VW-1:0];
              s1_load = 1'b1;
              s1_load_use = !err;
              s1_load_data.vertex = in_data.index[9:0];
              s1_load_data.status = err;
            end
            FUNC_RUN: state_next = ST_DRAIN;
            default: ;
          endcase
        end
      end
      // let a pending score read leave before the tables are touched
      ST_DRAIN: begin
        if (!s1_valid) begin
          cnt_next = '0;
          state_next = ST_CLR_CENT;
        end
      end
      // clear every score, at run start and after reset
      ST_CLR_CENT, ST_RST_CLR: begin
        cent_we = 1'b1;
        cent_waddr = cnt[VW-1:0];
        cnt_next = cnt + DW'(1);
        if (cnt == DW'(MAX_VERTICES - 1)) begin
          src_next = '0;
          state_next = (state == ST_CLR_CENT) ? ST_SRC : ST_IDLE;
        end
      end
      ST_SRC: begin
        cnt_next = '0;
        state_next = (src >= live_n) ? ST_DONE : ST_CLR;
      end
      // per-source clear of distance, path count and dependency
      ST_CLR: begin
        dist_we = 1'b1; dist_waddr = cnt[VW-1:0]; dist_wdata = DIST_NONE;
        pc_we = 1'b1;   pc_waddr = cnt[VW-1:0];
        dep_we = 1'b1;  dep_waddr = cnt[VW-1:0];
        cnt_next = cnt + DW'(1);
        if (cnt == live_n - DW'(1)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        dist_we = 1'b1; dist_waddr = src[VW-1:0];
        pc_we = 1'b1;   pc_waddr = src[VW-1:0]; pc_wdata = PC_W'(1);
        vo_we = 1'b1;   vo_waddr = '0; vo_wdata = src[VW-1:0];
        tail_next = DW'(1);
        head_next = '0;
        state_next = ST_F_POP;
      end
      // forward search
      ST_F_POP: begin
        if (head == tail) begin
          state_next = ST_B_POP;
        end else begin
          vo_raddr = head[VW-1:0];
          head_next = head + DW'(1);
          state_next = ST_F_V;
        end
      end
      ST_F_V, ST_B_V: begin
        v_next = vo_rdata;
        off_raddr = OAW'(vo_rdata);
        dist_raddr = vo_rdata;
        pc_raddr = vo_rdata;
        acc_next = '0;
        state_next = (state == ST_F_V) ? ST_F_OFF0 : ST_B_OFF0;
      end
      ST_F_OFF0, ST_B_OFF0: begin
        j_next = off_rdata;
        dv_next = dist_rdata;
        pcv_next = pc_rdata;
        off_raddr = OAW'({1'b0, v} + DW'(1));
        state_next = (state == ST_F_OFF0) ? ST_F_OFF1 : ST_B_OFF1;
      end
      ST_F_OFF1, ST_B_OFF1: begin
        jend_next = off_rdata;
        state_next = (state == ST_F_OFF1) ? ST_F_EDGE : ST_B_EDGE;
      end
      ST_F_EDGE, ST_B_EDGE: begin
        col_raddr = j[EW-1:0];
        if ((j < jend) && (j < live_m)) begin
          state_next = (state == ST_F_EDGE) ? ST_F_COL : ST_B_COL;
        end else begin
          state_next = (state == ST_F_EDGE) ? ST_F_POP : ST_B_STORE;
        end
      end
      ST_F_COL, ST_B_COL: begin
        w_next = col_rdata;
        dist_raddr = col_rdata;
        pc_raddr = col_rdata;
        dep_raddr = col_rdata;
        if ({1'b0, col_rdata} >= live_n) begin
          j_next = j + OW'(1);
          state_next = (state == ST_F_COL) ? ST_F_EDGE : ST_B_EDGE;
        end else begin
          state_next = (state == ST_F_COL) ? ST_F_W : ST_B_W;
        end
      end
      ST_F_W: begin
        if (dist_rdata == DIST_NONE) begin
          dist_we = 1'b1; dist_waddr = w; dist_wdata = dv_inc;
          if (tail < live_n) begin
            vo_we = 1'b1; vo_waddr = tail[VW-1:0]; vo_wdata = w;
            tail_next = tail + DW'(1);
          end
        end
        if (dist_eff == dv_inc) begin
          pc_we = 1'b1; pc_waddr = w;
          pc_wdata = pc_sum[PC_W] ? {PC_W{1'b1}} : pc_sum[PC_W-1:0];
        end
        j_next = j + OW'(1);
        state_next = ST_F_EDGE;
      end
      // backward sweep
      ST_B_POP: begin
        if (tail == '0) begin
          src_next = src + DW'(1);
          state_next = ST_SRC;
        end else begin
          vo_raddr = VW'(tail - DW'(1));
          tail_next = tail - DW'(1);
          state_next = ST_B_V;
        end
      end
      ST_B_W: begin
        if ((dist_rdata != dv_inc) || (pc_rdata == '0)) begin
          j_next = j + OW'(1);
          state_next = ST_B_EDGE;
        end else begin
          ratio_start = 1'b1;
          state_next = ST_B_WAIT;
        end
      end
      ST_B_WAIT: begin
        if (ratio_done) begin
          acc_next = acc_sum[SCORE_W] ? {SCORE_W{1'b1}} : acc_sum[SCORE_W-1:0];
          j_next = j + OW'(1);
          state_next = ST_B_EDGE;
        end
      end
      ST_B_STORE: begin
        dep_we = 1'b1; dep_waddr = v; dep_wdata = acc;
        if (v != src[VW-1:0]) begin
          cent_re = 1'b1;
          cent_raddr = v;
          state_next = ST_B_CENT;
        end else begin
          state_next = ST_B_POP;
        end
      end
      ST_B_CENT: begin
        cent_we = 1'b1; cent_waddr = v;
        cent_wdata = cent_sum[SCORE_W] ? {SCORE_W{1'b1}} : cent_sum[SCORE_W-1:0];
        state_next = ST_B_POP;
      end
      ST_DONE: begin
        if (!s1_valid) begin
          s1_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RST_CLR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    src <= src_next;   head <= head_next; tail <= tail_next;
    dv <= dv_next;     v <= v_next;       w <= w_next;
    j <= j_next;       jend <= jend_next; pcv <= pcv_next;   acc <= acc_next;
  end

  // result stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
    if (s1_move) begin
      if (s1_use_ram) begin
        out_data <= '{score: cent_rdata, vertex: s1_data.vertex,
                      status: s1_data.status};
      end else begin
        out_data <= s1_data;
      end
    end
    if (s1_load) begin
      s1_data    <= s1_load_data;
      s1_use_ram <= s1_load_use;
    end
  end

  bc_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 1)) u_offset (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .re(1'b1), .raddr(off_raddr), .rdata(off_rdata)
  );

  bc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_column (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .re(1'b1), .raddr(col_raddr), .rdata(col_rdata)
  );

  bc_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_distance (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(1'b1), .raddr(dist_raddr), .rdata(dist_rdata)
  );

  bc_ram #(.WIDTH(PC_W), .DEPTH(MAX_VERTICES)) u_path_count (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .re(1'b1), .raddr(pc_raddr), .rdata(pc_rdata)
  );

  bc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_dependency (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .re(1'b1), .raddr(dep_raddr), .rdata(dep_rdata)
  );

  bc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_centrality (
    .clk(clk), .we(cent_we), .waddr(cent_waddr), .wdata(cent_wdata),
    .re(cent_re), .raddr(cent_raddr), .rdata(cent_rdata)
  );

  bc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_visit_order (
    .clk(clk), .we(vo_we), .waddr(vo_waddr), .wdata(vo_wdata),
    .re(1'b1), .raddr(vo_raddr), .rdata(vo_rdata)
  );

  bc_ratio u_ratio (
    .clk(clk), .rst(rst), .start(ratio_start), .req(ratio_req),
    .done(ratio_done), .term(ratio_term)
  );

endmodule

[hw/rtl/bc_ram.sv]
// ----------------------------------------------------------------------------
// bc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bc_ratio.sv]
// ----------------------------------------------------------------------------
// bc_ratio
// Dependency term unit: bit-serial Q1.16 path ratio, then two registered
// multiplies and a saturating sum for ratio * (1 + dependency).
// ----------------------------------------------------------------------------
module bc_ratio (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  bc_pkg::ratio_req_t          req,
  output logic                        done,
  output logic [bc_pkg::SCORE_W-1:0]  term
);
  import bc_pkg::*;

  ratio_state_t state, state_next;

  logic [PC_W-1:0]  pcw;
  logic [PC_W-1:0]  rem;
  logic [16:0]      ratio;
  logic [4:0]       cnt;
  logic [32:0]      onep_hi;
  logic [15:0]      onep_lo;
  logic [49:0]      prod_hi;
  logic [32:0]      prod_lo;
  logic [48:0]      onep;
  logic [32:0]      rem2;
  logic             ge;
  logic [50:0]      sum;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result
  always_comb begin
    onep = 49'(req.dep) + 49'(1 << Q_FRAC);
    rem2 = {rem, 1'b0};
    ge   = rem2 >= {1'b0, pcw};
    sum  = {1'b0, prod_hi} + 51'(prod_lo[32:16]);
    term = (sum[50:48] != 3'd0) ? {SCORE_W{1'b1}} : sum[47:0];
    done = (state == RT_SUM);
    state_next = state;
    case (state)
      RT_IDLE: begin
        if (start) begin
          state_next = (req.pcv >= req.pcw) ? RT_MUL_HI : RT_DIV;
        end
      end
      RT_DIV: begin
        if (cnt == 5'd1) begin
          state_next = RT_MUL_HI;
        end
      end
      RT_MUL_HI: state_next = RT_MUL_LO;
      RT_MUL_LO: state_next = RT_SUM;
      RT_SUM:    state_next = RT_IDLE;
      default:   state_next = RT_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      RT_IDLE: begin
        if (start) begin
          onep_hi <= onep[48:16];
          onep_lo <= onep[15:0];
          pcw     <= req.pcw;
          rem     <= req.pcv;
          cnt     <= 5'd16;
          ratio   <= (req.pcv >= req.pcw) ? 17'h10000 : 17'd0;
        end
      end
      RT_DIV: begin
        rem   <= ge ? 32'(rem2 - {1'b0, pcw}) : rem2[31:0];
        ratio <= {ratio[15:0], ge};
        cnt   <= cnt - 5'd1;
      end
      RT_MUL_HI: prod_hi <= 50'(onep_hi) * 50'(ratio);
      RT_MUL_LO: prod_lo <= 33'(onep_lo) * 33'(ratio);
      default: ;
    endcase
  end

endmodule

[hw/rtl/bc_checker.sv]
// ----------------------------------------------------------------------------
// bc_checker
// Port-level checks for the betweenness centrality engine.
// ----------------------------------------------------------------------------
module bc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input bc_pkg::in_item_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input bc_pkg::out_item_t out_data
);
  import bc_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // rejected items carry no score
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.score == '0)
    else $error("error result with nonzero score");

  // no result right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // table and read items raise out_valid once through the result stage and output register
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func != FUNC_RUN |-> ##2 out_valid)
    else $error("missing result for table or read item");

endmodule

bind betweenness_centrality bc_checker u_bc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
